>>> rtl/crrq_pkg.sv
// Shared types, constants and helpers for the coalescing request ring queue.
// Used by the controller, the datapath, the top level and the checker.
package crrq_pkg;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_SLOTS);
  localparam int unsigned CNT_W       = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned ID_W        = 8;
  localparam int unsigned VOL_W       = 8;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned PCNT_W      = 4;

  localparam logic [VOL_W-1:0] VOLUME_MAX = 8'd128;

  typedef enum logic [STAT_W-1:0] {
    STAT_APPENDED = 3'd0,
    STAT_MERGED   = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_POPPED   = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    rd_head;
    logic    scan_adv;
    logic    finish;
    status_e status;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_pop;
    logic scan_end;
    logic cmp_vld;
    logic cmp_hit;
    logic empty;
    logic full;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(QUEUE_SLOTS - 1)) begin
      return '0;
    end else begin
      return idx + 1'b1;
    end
  endfunction

endpackage

>>> rtl/crrq_ctrl.sv
// Controller state machine of the coalescing request ring queue.
// Depends on crrq_pkg for the state, command and status types.
module crrq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output crrq_pkg::ctrl_cmd_t  cmd_o,
  input  crrq_pkg::dp_stat_t   stat_i
);
  import crrq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.status = STAT_APPENDED;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_pop) begin
          if (stat_i.empty) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = STAT_EMPTY;
            state_d      = S_IDLE;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_head = 1'b1;
            state_d       = S_POP;
          end
        end else if (stat_i.cmp_vld && stat_i.cmp_hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = STAT_MERGED;
          state_d      = S_IDLE;
        end else if (stat_i.scan_end) begin
          // Every pending entry has been compared without a match.
          cmd_o.finish = 1'b1;
          cmd_o.status = stat_i.full ? STAT_DROPPED : STAT_APPENDED;
          state_d      = S_IDLE;
        end else begin
          // Read the next entry while the previous one is compared.
          cmd_o.rd_en    = 1'b1;
          cmd_o.scan_adv = 1'b1;
        end
      end
      S_POP: begin
        cmd_o.finish = 1'b1;
        cmd_o.status = STAT_POPPED;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/crrq_dp.sv
// Datapath of the coalescing request ring queue: entry memory, ring pointers,
// scan pointer and result register. Depends on crrq_pkg.
module crrq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  crrq_pkg::ctrl_cmd_t                 cmd_i,
  output crrq_pkg::dp_stat_t                  stat_o,
  input  logic                                operation_i,
  input  logic [crrq_pkg::ID_W-1:0]           sound_id_i,
  input  logic [crrq_pkg::VOL_W-1:0]          volume_i,
  output logic                                done_o,
  output logic [crrq_pkg::STAT_W-1:0]         status_o,
  output logic [crrq_pkg::ID_W-1:0]           popped_id_o,
  output logic [crrq_pkg::VOL_W-1:0]          popped_volume_o,
  output logic [crrq_pkg::PCNT_W-1:0]         pending_count_o
);
  import crrq_pkg::*;

  localparam int unsigned WORD_W = ID_W + VOL_W;

  logic [WORD_W-1:0] mem [QUEUE_SLOTS];

  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [VOL_W-1:0]  vol_q;
  logic [VOL_W-1:0]  vol_sat;
  logic [IDX_W-1:0]  head_q, tail_q, scan_q, cmp_idx_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cmp_vld_q;
  logic [WORD_W-1:0] rd_q;
  logic [ID_W-1:0]   rd_id;
  logic [VOL_W-1:0]  rd_vol, vol_max;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              do_append, do_merge, do_pop, wr_en;
  logic [CNT_W+PCNT_W-1:0] cnt_ext;

  logic              done_q;
  status_e           status_q;
  logic [ID_W-1:0]   pid_q;
  logic [VOL_W-1:0]  pvol_q;
  logic [PCNT_W-1:0] pcnt_q;

  assign vol_sat = (volume_i > VOLUME_MAX) ? VOLUME_MAX : volume_i;

  assign rd_id   = rd_q[WORD_W-1:VOL_W];
  assign rd_vol  = rd_q[VOL_W-1:0];
  assign vol_max = (rd_vol > vol_q) ? rd_vol : vol_q;

  assign do_append = cmd_i.finish && (cmd_i.status == STAT_APPENDED);
  assign do_merge  = cmd_i.finish && (cmd_i.status == STAT_MERGED);
  assign do_pop    = cmd_i.finish && (cmd_i.status == STAT_POPPED);
  assign wr_en     = do_append || do_merge;
  assign wr_addr   = do_append ? tail_q : cmp_idx_q;
  assign wr_data   = do_append ? {id_q, vol_q} : {rd_id, vol_max};
  assign rd_addr   = cmd_i.rd_head ? head_q : scan_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_append) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign cnt_ext = {{PCNT_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Item payload and compare slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      id_q  <= sound_id_i;
      vol_q <= vol_sat;
    end
    if (cmd_i.scan_adv) begin
      cmp_idx_q <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        scan_q    <= head_q;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_adv) begin
        scan_q    <= next_slot(scan_q);
        cmp_vld_q <= 1'b1;
      end
      if (do_append) begin
        tail_q <= next_slot(tail_q);
      end
      if (do_pop) begin
        head_q <= next_slot(head_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      pid_q    <= do_pop ? rd_id : '0;
      pvol_q   <= do_pop ? rd_vol : '0;
      pcnt_q   <= cnt_ext[PCNT_W-1:0];
    end
  end

  assign stat_o.is_pop   = (op_q == OP_POP);
  assign stat_o.scan_end = (scan_q == tail_q);
  assign stat_o.cmp_vld  = cmp_vld_q;
  assign stat_o.cmp_hit  = (rd_id == id_q);
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CNT_W'(QUEUE_SLOTS - 1));

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign popped_id_o     = pid_q;
  assign popped_volume_o = pvol_q;
  assign pending_count_o = pcnt_q;

endmodule

>>> rtl/coalescing_request_ring_queue.sv
// Top level of the coalescing request ring queue: controller plus datapath.
// Depends on crrq_pkg, crrq_ctrl and crrq_dp.
//
//   channel   strobe / handshake       word fields
//   --------  -----------------------  ------------------------------------------
//   request   start in, busy out       operation_i, sound_id_i, volume_i
//   result    done_o (one cycle)       status_o, popped_id_o, popped_volume_o,
//                                      pending_count_o
//
// A request is taken when start is high and busy is low; every request gives
// one result word. A push reads one pending entry per cycle from the single
// read port of the entry memory, so busy stays high until every pending entry
// has been compared, shorter when a match is found early; a pop reads the head
// entry, but a pop on an empty ring finishes without a read. The result word
// is on the ports in the first cycle with busy low, while a new request may
// already be taken. Reset clears the ring pointers and count; entry contents
// are left as they are. Results cannot be held off.
module coalescing_request_ring_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [crrq_pkg::ID_W-1:0]           sound_id_i,
  input  logic [crrq_pkg::VOL_W-1:0]          volume_i,
  output logic                                done_o,
  output logic [crrq_pkg::STAT_W-1:0]         status_o,
  output logic [crrq_pkg::ID_W-1:0]           popped_id_o,
  output logic [crrq_pkg::VOL_W-1:0]          popped_volume_o,
  output logic [crrq_pkg::PCNT_W-1:0]         pending_count_o
);
  import crrq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  crrq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  crrq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .sound_id_i      (sound_id_i),
    .volume_i        (volume_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .popped_id_o     (popped_id_o),
    .popped_volume_o (popped_volume_o),
    .pending_count_o (pending_count_o)
  );

endmodule

>>> rtl/crrq_checker.sv
// Port-level checker for the coalescing request ring queue, bound to the top.
// Depends on crrq_pkg for the status codes.
module crrq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic [crrq_pkg::STAT_W-1:0]         status_o,
  input logic [crrq_pkg::ID_W-1:0]           popped_id_o,
  input logic [crrq_pkg::VOL_W-1:0]          popped_volume_o,
  input logic [crrq_pkg::PCNT_W-1:0]         pending_count_o
);
  import crrq_pkg::*;

  // An accepted request always occupies the block on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy afterwards");

  // A result word follows exactly when the block has just finished.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $fell(busy))
    else $error("result word without a finished request");

  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("request finished without a result word");

  a_pop_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_POPPED)) |->
      ((popped_id_o == '0) && (popped_volume_o == '0)))
    else $error("popped fields nonzero on a non-pop result");

  a_append_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == STAT_APPENDED) || (status_o == STAT_MERGED))) |->
      (pending_count_o != '0))
    else $error("queue reported empty after a push was stored");

endmodule

bind coalescing_request_ring_queue crrq_checker u_crrq_checker (.*);

>>> verif/coalescing_request_ring_queue_test.sv
// Self-checking testbench for the coalescing request ring queue.
// Depends on crrq_pkg and the coalescing_request_ring_queue top level only.
`timescale 1ns / 100ps

module coalescing_request_ring_queue_test;
  import crrq_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    pid;
    logic [VOL_W-1:0]   pvol;
    logic [PCNT_W-1:0]  count;
  } result_word_t;

  // Tracks the ring contents and the result words still to come back.
  class ring_ledger;
    logic [ID_W-1:0]  slot_id  [QUEUE_SLOTS];
    logic [VOL_W-1:0] slot_vol [QUEUE_SLOTS];
    int unsigned      head = 0;
    int unsigned      tail = 0;
    result_word_t     awaited[$];
    int unsigned      errors = 0;
    int unsigned      checked = 0;
    int unsigned      by_status[5] = '{default: 0};

    function void note_request(op_e op, logic [ID_W-1:0] id, logic [VOL_W-1:0] vol);
      result_word_t     w;
      logic [VOL_W-1:0] v;
      int unsigned      i;
      bit               hit;
      w = '0;
      v = (vol > VOLUME_MAX) ? VOLUME_MAX : vol;
      if (op == OP_PUSH) begin
        hit = 1'b0;
        i = head;
        // Oldest pending entry first; the first id match absorbs the request.
        while (i != tail && !hit) begin
          if (slot_id[i] == id) begin
            if (v > slot_vol[i]) slot_vol[i] = v;
            hit = 1'b1;
          end else begin
            i = (i + 1) % QUEUE_SLOTS;
          end
        end
        if (hit) begin
          w.status = STAT_MERGED;
        end else if ((tail + 1) % QUEUE_SLOTS == head) begin
          w.status = STAT_DROPPED;
        end else begin
          slot_id[tail]  = id;
          slot_vol[tail] = v;
          tail = (tail + 1) % QUEUE_SLOTS;
          w.status = STAT_APPENDED;
        end
      end else if (head == tail) begin
        w.status = STAT_EMPTY;
      end else begin
        w.pid  = slot_id[head];
        w.pvol = slot_vol[head];
        head = (head + 1) % QUEUE_SLOTS;
        w.status = STAT_POPPED;
      end
      w.count = PCNT_W'((tail + QUEUE_SLOTS - head) % QUEUE_SLOTS);
      awaited.push_back(w);
    endfunction

    function void check_word(logic [STAT_W-1:0] st, logic [ID_W-1:0] pid,
                             logic [VOL_W-1:0] pvol, logic [PCNT_W-1:0] cnt);
      result_word_t w;
      if (awaited.size() == 0) begin
        $error("result word with no request outstanding: status %0d", st);
        errors++;
        return;
      end
      w = awaited.pop_front();
      checked++;
      by_status[w.status]++;
      if (st !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, st);
        errors++;
      end
      if (pid !== w.pid) begin
        $error("popped_id: expected %0d, actual %0d", w.pid, pid);
        errors++;
      end
      if (pvol !== w.pvol) begin
        $error("popped_volume: expected %0d, actual %0d", w.pvol, pvol);
        errors++;
      end
      if (cnt !== w.count) begin
        $error("pending_count: expected %0d, actual %0d", w.count, cnt);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned RANDOM_WORDS = 900;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               operation_i = OP_PUSH;
  logic [ID_W-1:0]    sound_id_i = '0;
  logic [VOL_W-1:0]   volume_i = '0;
  logic               done_o;
  logic [STAT_W-1:0]  status_o;
  logic [ID_W-1:0]    popped_id_o;
  logic [VOL_W-1:0]   popped_volume_o;
  logic [PCNT_W-1:0]  pending_count_o;

  ring_ledger ledger;

  always #2 clk_i = ~clk_i;

  coalescing_request_ring_queue i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .sound_id_i      (sound_id_i),
    .volume_i        (volume_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .popped_id_o     (popped_id_o),
    .popped_volume_o (popped_volume_o),
    .pending_count_o (pending_count_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      ledger.check_word(status_o, popped_id_o, popped_volume_o, pending_count_o);
    end
  end

  // Called right after a rising edge; returns at the edge that took the word.
  task automatic send_word(input op_e op, input logic [ID_W-1:0] id,
                           input logic [VOL_W-1:0] vol);
    if (!start) start <= 1'b1;
    operation_i <= op;
    sound_id_i  <= id;
    volume_i    <= vol;
    do begin
      @(posedge clk_i);
    end while (busy);
    ledger.note_request(op, id, vol);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0:       return VOL_W'($urandom_range(129, 255));
      1:       return VOLUME_MAX;
      2:       return '0;
      default: return VOL_W'($urandom_range(0, 128));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned push_pct;
    op_e         op;
    logic [ID_W-1:0] id;

    ledger = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty pop, field extremes, saturation, merges, a full ring.
    send_word(OP_POP, 8'd0, 8'd0);
    send_word(OP_PUSH, 8'd0, 8'd0);
    send_word(OP_PUSH, 8'd255, 8'd128);
    send_word(OP_PUSH, 8'd0, 8'd200);
    send_word(OP_PUSH, 8'd255, 8'd3);
    for (int k = 1; k <= 13; k++) begin
      send_word(OP_PUSH, ID_W'(k), VOL_W'(k * 10));
    end
    send_word(OP_PUSH, 8'd100, 8'd255);
    send_word(OP_PUSH, 8'd5, 8'd255);
    for (int k = 0; k < 5; k++) begin
      send_word(OP_POP, 8'hff, 8'hff);
    end
    pause(3);

    // Random part: bursts that lean toward pushes or pops so the ring sweeps
    // between empty and full, with ids drawn mostly from a small set.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 30);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 55;
      endcase
      for (int k = 0; k < burst; k++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        id = ($urandom_range(0, 9) < 6) ? ID_W'($urandom_range(0, 11))
                                        : ID_W'($urandom_range(0, 255));
        send_word(op, id, pick_volume());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 20));
      end
    end

    start <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (ledger.awaited.size() != 0) begin
      $error("%0d result words never arrived", ledger.awaited.size());
      ledger.errors++;
    end
    $display("Checked %0d result words: %0d appended, %0d merged, %0d dropped,",
             ledger.checked, ledger.by_status[STAT_APPENDED],
             ledger.by_status[STAT_MERGED], ledger.by_status[STAT_DROPPED]);
    $display("  %0d popped, %0d pops on an empty ring.",
             ledger.by_status[STAT_POPPED], ledger.by_status[STAT_EMPTY]);
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
